### src/block_bitmap_allocator_defines.svh
// Assertion macros for the block bitmap allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bba assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bba assertion failed");

`endif

### src/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

   localparam int BYTES_PER_WORD = 64;
   localparam int LANE_W         = 6;
   localparam int BIT_W          = 3;
   localparam int WORD_W         = BYTES_PER_WORD * 8;
   localparam int BASE_WORDS     = 1024 / BYTES_PER_WORD;
   localparam int INDEX_W        = 15;
   localparam int BYTE_IDX_W     = 12;
   localparam logic [7:0] FULL_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      OP_LOAD_BYTE  = 2'd0,
      OP_ALLOC      = 2'd1,
      OP_LOAD_COUNT = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [BYTE_IDX_W-1:0]   byte_index;
      logic [7:0]              byte_value;
      logic [15:0]             group_free_in;
      logic [31:0]             total_free_in;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] claim_index;
      logic               alloc_ok;
      logic [15:0]        group_free;
      logic [31:0]        total_free;
   } rsp_type;

endpackage

### src/block_bitmap_allocator.sv
// Byte loads, counter loads and the unused opcode go from S_IDLE to S_OUT, where rsp_valid is
// registered. Allocation reads the bitmap one 64-byte word at a time in S_SCAN through the
// single read port of the bitmap memory, at most 16, 32 or 64 words for 1, 2 and 4 KiB blocks,
// then goes to S_OUT. One request is in work at a time; the next can be taken in the same cycle
// as rsp_valid rises, and a result held by rsp_stall keeps the request after it waiting. Reset
// clears the free counters, the block size register and control state, not the bitmap.
`timescale 1ns / 1ps
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator #(
   parameter int BITMAP_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bba_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_wdata
);

   localparam int WORDS = BITMAP_BYTES / bba_pkg::BYTES_PER_WORD;
   localparam int AW    = $clog2(WORDS);
   localparam logic [7:0] WORDS8 = 8'(WORDS);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_type;

   state_type                      state_ff, state_in;
   logic [1:0]                     lbs_ff, lbs_in;
   logic [15:0]                    group_ff, group_in;
   logic [31:0]                    total_ff, total_in;
   logic [AW-1:0]                  ptr_ff, ptr_in;
   logic                           res_ok_ff, res_ok_in;
   logic [bba_pkg::INDEX_W-1:0]    res_index_ff, res_index_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [bba_pkg::WORD_W-1:0]     mem [WORDS];
   logic [bba_pkg::WORD_W-1:0]     rd_data_ff;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [bba_pkg::LANE_W-1:0]     wr_lane;
   logic [7:0]                     wr_byte;

   logic                           accept;
   logic [7:0]                     lim_raw;
   logic [7:0]                     limit8;
   logic                           last_word;
   logic                           found;
   logic [bba_pkg::LANE_W-1:0]     lane;
   logic [7:0]                     sel_byte;
   logic [bba_pkg::BIT_W-1:0]      bitpos;
   logic                           load_in_range;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign lim_raw   = 8'(bba_pkg::BASE_WORDS) << lbs_ff;
   assign limit8    = (lim_raw > WORDS8) ? WORDS8 : lim_raw;
   assign last_word = (8'(ptr_ff) == (limit8 - 8'd1));
   assign load_in_range = ({1'b0, req_data.byte_index} < 13'(BITMAP_BYTES));

   always_comb begin
      found = 1'b0;
      lane  = '0;
      for (int i = bba_pkg::BYTES_PER_WORD - 1; i >= 0; i--) begin
         if (rd_data_ff[i*8 +: 8] != bba_pkg::FULL_BYTE) begin
            found = 1'b1;
            lane  = bba_pkg::LANE_W'(i);
         end
      end
   end

   assign sel_byte = rd_data_ff[{lane, 3'b000} +: 8];

   always_comb begin
      bitpos = '0;
      for (int j = 7; j >= 0; j--) begin
         if (!sel_byte[j]) begin
            bitpos = bba_pkg::BIT_W'(j);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      lbs_in       = lbs_ff;
      group_in     = group_ff;
      total_in     = total_ff;
      ptr_in       = ptr_ff;
      res_ok_in    = res_ok_ff;
      res_index_in = res_index_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = req_data.byte_index[6 +: AW];
      wr_lane      = req_data.byte_index[bba_pkg::LANE_W-1:0];
      wr_byte      = req_data.byte_value;

      if (csr_valid && csr_ready) begin
         lbs_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_ok_in    = 1'b0;
               res_index_in = '0;
               state_in     = S_OUT;
               unique case (req_data.opcode)
                  bba_pkg::OP_LOAD_BYTE: begin
                     wr_en = load_in_range;
                  end
                  bba_pkg::OP_ALLOC: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     ptr_in   = '0;
                     state_in = S_SCAN;
                  end
                  bba_pkg::OP_LOAD_COUNT: begin
                     group_in = req_data.group_free_in;
                     total_in = req_data.total_free_in;
                  end
                  bba_pkg::OP_NONE: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (found) begin
               wr_en        = 1'b1;
               wr_addr      = ptr_ff;
               wr_lane      = lane;
               wr_byte      = sel_byte | (8'd1 << bitpos);
               res_ok_in    = 1'b1;
               res_index_in = bba_pkg::INDEX_W'({ptr_ff, lane, bitpos});
               group_in     = group_ff - 16'(group_ff != 16'd0);
               total_in     = total_ff - 32'(total_ff != 32'd0);
               state_in     = S_OUT;
            end else if (last_word) begin
               state_in = S_OUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(1);
               ptr_in  = ptr_ff + AW'(1);
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.claim_index = res_index_ff;
               rsp_data_in.alloc_ok    = res_ok_ff;
               rsp_data_in.group_free  = group_ff;
               rsp_data_in.total_free  = total_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lbs_ff       <= '0;
         group_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lbs_ff       <= lbs_in;
         group_ff     <= group_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      res_ok_ff    <= res_ok_in;
      res_index_ff <= res_index_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `BBA_ASSERT_NOW(a_fail_index_zero, rsp_valid_ff && !rsp_data_ff.alloc_ok,
      rsp_data_ff.claim_index == '0)
   `BBA_ASSERT_NOW(a_scan_in_limit, state_ff == S_SCAN, 8'(ptr_ff) < limit8)
   `BBA_ASSERT_NEXT(a_alloc_scans, accept && req_data.opcode == bba_pkg::OP_ALLOC,
      state_ff == S_SCAN)
   `BBA_ASSERT_NEXT(a_group_dec, state_ff == S_SCAN && found && group_ff != 16'd0,
      group_ff == $past(group_ff) - 16'd1)

endmodule
